FILE: src/bmh_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
// Depends on nothing; the datapath, controller and top-level unit import it.
`default_nettype none
package bmh_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W = 32;
  localparam logic signed [KEY_W-1:0] INT_MAX = 32'sh7fffffff;
  localparam logic signed [KEY_W-1:0] INT_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_EXTRACT = 3'd1,
    OP_DELETE = 3'd2,
    OP_DECREASE = 3'd3,
    OP_INCREASE = 3'd4
  } op_t;

  // Operation codes with no function; they complete with nothing changed.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_SAME = 3'd3,
    ST_FULL = 3'd4
  } status_t;

  // Read address selects used by the controller.
  typedef enum logic [2:0] {
    AD_CUR = 3'd0,
    AD_PAR = 3'd1,
    AD_LEFT = 3'd2,
    AD_RIGHT = 3'd3,
    AD_LAST = 3'd4,
    AD_ROOT = 3'd5
  } addr_sel_t;

  // Write data selects; the write address is always the current slot.
  typedef enum logic [1:0] {
    WD_A = 2'd0,
    WD_RDATA = 2'd1,
    WD_CHILD = 2'd2
  } wdata_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    wdata_sel_t wr_data;
    logic       cur_to_count;
    logic       cur_to_par;
    logic       cur_to_child;
    logic       cur_to_root;
    logic       a_from_key;
    logic       a_from_rdata;
    logic       cap_b;
    logic       v_from_rdata;
    logic       v_max;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic cur_zero;
    logic full;
    logic empty;
    logic pos_bad;
    logic key_ge;
    logic key_le;
    logic par_le_a;
    logic left_ok;
    logic right_ok;
    logic dn_move;
  } stat_t;
endpackage
`default_nettype wire

FILE: src/bmh_if.sv
// Valid/ready channel interfaces for operations and results.
// Depends on no other file; the field widths are written out in place.
`default_nettype none
interface bmh_op_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [5:0] position;
  logic signed [31:0] key;
  modport source (output valid, operation, position, key, input ready);
  modport sink (input valid, operation, position, key, output ready);
endinterface

interface bmh_res_if;
  logic       valid;
  logic       ready;
  logic signed [31:0] value;
  logic [2:0] status;
  logic [6:0] count;
  modport source (output valid, value, status, count, input ready);
  modport sink (input valid, value, status, count, output ready);
endinterface
`default_nettype wire

FILE: src/bmh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: src/bmh_datapath.sv
// Heap datapath: index registers, key holding registers, count, result registers and heap RAM.
// Depends on bmh_pkg and bmh_ram.
`default_nettype none
module bmh_datapath import bmh_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [5:0]  in_position,
  input  wire logic signed [31:0] in_key,
  output stat_t            stat,
  output logic signed [31:0] res_value,
  output logic [$clog2(CAPACITY+1)-1:0] res_count
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  // Child indexes of the deepest slot need up to two bits more than the address.
  localparam int XW = AW + 2;

  logic [CW-1:0] count, last_c;
  logic [AW-1:0] cur, par, last, left, right, child, raddr;
  logic [XW-1:0] left_x, right_x, count_x;
  logic signed [31:0] key_r, a, b, v;
  logic signed [31:0] rdata, wdata, child_key;
  logic left_ok, right_ok, go_left, go_right;

  // Neighbor indexes of the current slot.
  assign par = (cur - AW'(1)) >> 1;
  assign left_x = {1'b0, cur, 1'b1};
  assign right_x = left_x + XW'(1);
  assign count_x = XW'(count);
  assign left = left_x[AW-1:0];
  assign right = right_x[AW-1:0];
  assign last_c = count - CW'(1);
  assign last = last_c[AW-1:0];
  assign left_ok = (left_x < count_x);
  assign right_ok = (right_x < count_x);

  // The moving key sits in a; pick the smaller child if it beats a.
  assign go_left = (b < a);
  assign go_right = right_ok && (rdata < (go_left ? b : a));
  assign child = go_right ? right : left;
  assign child_key = go_right ? rdata : b;

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      AD_CUR: raddr = cur;
      AD_PAR: raddr = par;
      AD_LEFT: raddr = left;
      AD_RIGHT: raddr = right;
      AD_LAST: raddr = last;
      AD_ROOT: raddr = '0;
      default: raddr = cur;
    endcase
  end

  // Write data selection.
  always_comb begin
    unique case (cmd.wr_data)
      WD_A: wdata = a;
      WD_RDATA: wdata = rdata;
      WD_CHILD: wdata = child_key;
      default: wdata = a;
    endcase
  end

  bmh_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(cmd.wr_en), .waddr(cur), .wdata(wdata),
    .re(cmd.rd_en), .raddr(raddr), .rdata(rdata)
  );

  // Status flags for the controller.
  always_comb begin
    stat.cur_zero = (cur == '0);
    stat.full = (count == CW'(CAPACITY));
    stat.empty = (count == '0);
    stat.pos_bad = (int'(in_position) >= int'(count));
    stat.key_ge = (key_r >= rdata);
    stat.key_le = (key_r <= rdata);
    stat.par_le_a = (rdata <= a);
    stat.left_ok = left_ok;
    stat.right_ok = right_ok;
    stat.dn_move = go_left || go_right;
  end

  // Count and result registers, then index and key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      res_value <= '0;
      res_count <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.res_load) begin
        res_value <= v;
        res_count <= count;
      end
    end
    if (cmd.load_item) begin
      key_r <= in_key;
      cur <= AW'(in_position);
    end else if (cmd.cur_to_count) begin
      cur <= count[AW-1:0];
    end else if (cmd.cur_to_par) begin
      cur <= par;
    end else if (cmd.cur_to_child) begin
      cur <= child;
    end else if (cmd.cur_to_root) begin
      cur <= '0;
    end
    if (cmd.v_max) begin
      v <= INT_MAX;
    end else if (cmd.load_item) begin
      v <= '0;
    end else if (cmd.v_from_rdata) begin
      v <= rdata;
    end
    if (cmd.a_from_key) begin
      a <= key_r;
    end else if (cmd.a_from_rdata) begin
      a <= rdata;
    end
    if (cmd.cap_b) begin
      b <= rdata;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY) else $error("count beyond capacity");
endmodule
`default_nettype wire

FILE: src/bmh_ctrl.sv
// Heap controller: sequences reads, compares and moves for each operation.
// Depends on bmh_pkg.
`default_nettype none
module bmh_ctrl import bmh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_op,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic [2:0]      res_status,
  input  wire stat_t      stat,
  output cmd_t            cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_INS, S_UP_RD, S_UP_CMP, S_UP_FIN,
    S_EXT_RD, S_TAKE, S_TAKE_LAST,
    S_DEL_RD, S_DEL_WR, S_CHG_RD, S_CHG_CMP,
    S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_FIN, S_RESP
  } state_t;

  state_t     state;
  logic [2:0] op;
  status_t    op_status;
  logic       accept, res_free, res_valid_next;

  // A waiting result sits in its own register, so a new item can start.
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign res_free = !res_valid || res_ready;
  assign res_valid_next = (res_valid && !res_ready) || (state == S_RESP && res_free);

  // Command decode per state.
  always_comb begin
    cmd = '0;
    cmd.rd_sel = AD_CUR;
    cmd.wr_data = WD_A;
    unique case (state)
      S_IDLE: begin
        cmd.load_item = accept;
        cmd.v_max = accept && (in_op == OP_EXTRACT) && stat.empty;
      end
      S_INS: begin
        cmd.cur_to_count = 1'b1; cmd.cnt_inc = 1'b1; cmd.a_from_key = 1'b1;
      end
      S_UP_RD: begin cmd.rd_en = !stat.cur_zero; cmd.rd_sel = AD_PAR; end
      S_UP_CMP: if (!stat.par_le_a) begin
        cmd.wr_en = 1'b1; cmd.wr_data = WD_RDATA; cmd.cur_to_par = 1'b1;
      end
      S_UP_FIN: cmd.wr_en = 1'b1;
      S_EXT_RD: begin cmd.rd_en = 1'b1; cmd.rd_sel = AD_ROOT; end
      S_TAKE: begin
        cmd.v_from_rdata = (op == OP_EXTRACT); cmd.cnt_dec = 1'b1;
        cmd.rd_en = 1'b1; cmd.rd_sel = AD_LAST;
      end
      S_TAKE_LAST: begin cmd.a_from_rdata = 1'b1; cmd.cur_to_root = 1'b1; end
      S_DEL_RD: begin cmd.rd_en = !stat.cur_zero; cmd.rd_sel = AD_PAR; end
      S_DEL_WR: begin
        cmd.wr_en = 1'b1; cmd.wr_data = WD_RDATA; cmd.cur_to_par = 1'b1;
      end
      S_CHG_RD: begin cmd.rd_en = 1'b1; cmd.rd_sel = AD_CUR; end
      S_CHG_CMP: cmd.a_from_key = 1'b1;
      S_DN_RDL: begin cmd.rd_en = stat.left_ok; cmd.rd_sel = AD_LEFT; end
      S_DN_RDR: begin
        cmd.cap_b = 1'b1; cmd.rd_en = stat.right_ok; cmd.rd_sel = AD_RIGHT;
      end
      S_DN_CMP: if (stat.dn_move) begin
        cmd.wr_en = 1'b1; cmd.wr_data = WD_CHILD; cmd.cur_to_child = 1'b1;
      end
      S_DN_FIN: cmd.wr_en = 1'b1;
      S_RESP: cmd.res_load = res_free;
      default: ;
    endcase
  end

  // State register and registered result fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      res_status <= ST_DONE;
      op <= OP_INSERT;
      op_status <= ST_DONE;
    end else begin
      res_valid <= res_valid_next;
      unique case (state)
        S_IDLE: if (accept) begin
          op <= in_op;
          case (in_op)
            OP_INSERT: begin
              if (stat.full) begin
                op_status <= ST_FULL; state <= S_RESP;
              end else begin
                op_status <= ST_DONE; state <= S_INS;
              end
            end
            OP_EXTRACT: begin
              if (stat.empty) begin
                op_status <= ST_EMPTY; state <= S_RESP;
              end else begin
                op_status <= ST_DONE; state <= S_EXT_RD;
              end
            end
            OP_DELETE: begin
              if (stat.pos_bad) begin
                op_status <= ST_RANGE; state <= S_RESP;
              end else begin
                op_status <= ST_DONE; state <= S_DEL_RD;
              end
            end
            OP_DECREASE: begin
              if (stat.pos_bad) begin
                op_status <= ST_RANGE; state <= S_RESP;
              end else begin
                op_status <= ST_DONE; state <= S_CHG_RD;
              end
            end
            OP_INCREASE: begin
              if (stat.pos_bad) begin
                op_status <= ST_RANGE; state <= S_RESP;
              end else begin
                op_status <= ST_DONE; state <= S_CHG_RD;
              end
            end
            default: begin
              op_status <= ST_DONE; state <= S_RESP;
            end
          endcase
        end
        S_INS: state <= S_UP_RD;
        S_UP_RD: state <= stat.cur_zero ? S_UP_FIN : S_UP_CMP;
        S_UP_CMP: state <= stat.par_le_a ? S_UP_FIN : S_UP_RD;
        S_UP_FIN: state <= S_RESP;
        S_EXT_RD: state <= S_TAKE;
        S_TAKE: state <= S_TAKE_LAST;
        S_TAKE_LAST: state <= stat.empty ? S_RESP : S_DN_RDL;
        S_DEL_RD: state <= stat.cur_zero ? S_TAKE : S_DEL_WR;
        S_DEL_WR: state <= S_DEL_RD;
        S_CHG_RD: state <= S_CHG_CMP;
        S_CHG_CMP: begin
          if ((op == OP_DECREASE && stat.key_ge) || (op == OP_INCREASE && stat.key_le)) begin
            op_status <= ST_SAME; state <= S_RESP;
          end else if (op == OP_DECREASE) begin
            state <= S_UP_RD;
          end else begin
            state <= S_DN_RDL;
          end
        end
        S_DN_RDL: state <= stat.left_ok ? S_DN_RDR : S_DN_FIN;
        S_DN_RDR: state <= S_DN_CMP;
        S_DN_CMP: state <= stat.dn_move ? S_DN_RDL : S_DN_FIN;
        S_DN_FIN: state <= S_RESP;
        S_RESP: if (res_free) begin
          res_status <= op_status; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A waiting result holds, and the datapath never gets conflicting commands.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_status)) else $error("result changed while held");
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.cnt_inc && cmd.cnt_dec)) else $error("count moved both ways");
  assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !cmd.rd_en) else $error("read and write in one cycle");
endmodule
`default_nettype wire

FILE: src/binary_min_heap_priority_queue_unit.sv
// Binary min-heap priority queue unit: one operation in, one result out, a
// controller stepping a datapath over a single heap RAM with registered reads.
// The moving key is held in a register while slots shift, so climbing steps
// through a parent read and a compare per level and descending through a left
// read, a right read and a compare. A new item is taken only in the idle
// state, after the last operation has loaded its result register. The result
// sits in its own register, so a stalled result only holds the unit once the
// next operation is ready to report. Depends on bmh_pkg, bmh_if and the
// controller, datapath and RAM modules.
`default_nettype none
module binary_min_heap_priority_queue_unit import bmh_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  bmh_op_if.sink    op_in,
  bmh_res_if.source res_out
);
  cmd_t  cmd;
  stat_t stat;
  logic signed [31:0] res_value;
  logic [$clog2(CAPACITY+1)-1:0] res_count;
  logic [2:0] res_status;

  bmh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(op_in.valid), .in_ready(op_in.ready),
    .in_op(op_in.operation), .res_valid(res_out.valid), .res_ready(res_out.ready),
    .res_status(res_status), .stat(stat), .cmd(cmd)
  );

  bmh_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_position(op_in.position),
    .in_key(op_in.key), .stat(stat), .res_value(res_value), .res_count(res_count)
  );

  // Result fields come straight from the result registers.
  assign res_out.status = res_status;
  assign res_out.count = 7'(res_count);
  assign res_out.value = res_value;
endmodule
`default_nettype wire
